// File: hdl/gha_pkg.sv
package gha_pkg;

  // Default pool depth.
  localparam int SLOTS_DEFAULT = 64;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 1;

  // Generation given to a slot that was never freed since reset or clear.
  localparam logic [15:0] GEN_START = 16'd1;

  // Operation codes carried on the input tuser.
  typedef enum logic [2:0] {
    OP_SPAWN   = 3'd0,
    OP_DESTROY = 3'd1,
    OP_ALIVE   = 3'd2,
    OP_FIND    = 3'd3,
    OP_NTH     = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } st_t;

  // One request as it arrives on the input stream.
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] hdl;
    logic [15:0] typ;
    logic [15:0] cur;
  } req_t;

  // One result as it leaves on the output stream.
  typedef struct packed {
    logic        ok;
    logic [31:0] hdl;
    logic [15:0] slot;
    logic [15:0] ncur;
    logic [15:0] live;
  } res_t;

  // Write and read commands from the sequencer to the slot store.
  typedef struct packed {
    logic        rd_en;
    logic        spawn;
    logic        destroy;
    logic        clear_all;
    logic [15:0] typ;
    logic [15:0] gen;
  } store_ctl_t;

  // Registered read data of one slot.
  typedef struct packed {
    logic        act;
    logic [15:0] gen;
    logic [15:0] typ;
  } store_rd_t;

endpackage

// File: hdl/generational_handle_allocator.sv
// Generational handle allocator.
// Requests arrive on the in_ stream: in_tuser carries the operation (spawn,
// destroy, alive query, find by type, n-th active, clear) and in_tdata the
// handle, the entity type and the cursor. Each request yields one result on
// the out_ stream: out_tuser is the ok flag, out_tdata holds the handle, the
// slot, the next cursor and the live count after the operation.
// One request is in work at a time; in_tready is low from the transfer until
// the result has been moved into the output register. Spawn, find and n-th
// active walk the slots one per cycle through a single compare unit fed by
// the registered read port of the slot memories, visiting at most SLOTS
// slots. Destroy and alive query visit one slot; clear, a full pool, a bad
// handle or a cursor out of range go straight to the result without
// visiting any slot. The next request can transfer in the same cycle that
// out_tvalid rises.
// When the receiver stalls, the result waits in the output register and the
// next request is still taken and worked on; it then waits for the register.
// After reset every slot is free with generation 1, the live count is 0 and
// out_tvalid is low. Clear restores the slots and the live count to that state.
module generational_handle_allocator #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // handle_in [31:0], entity_type [47:32], cursor [63:48]
  input  logic [gha_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func [2:0]
  input  logic [gha_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // handle_out [31:0], slot [47:32], next_cursor [63:48], live_count [79:64]
  output logic [gha_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // ok [0]
  output logic [gha_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import gha_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  req_t          req;
  res_t          res;
  store_ctl_t    ctl;
  store_rd_t     rd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  // Unpack the request fields from the stream.
  assign req.func = in_tuser;
  assign req.hdl  = in_tdata[31:0];
  assign req.typ  = in_tdata[47:32];
  assign req.cur  = in_tdata[63:48];

  gha_seq #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .rd        (rd)
  );

  gha_store #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd      (rd)
  );

  // Pack the result onto the stream.
  assign out_tdata = {res.live, res.ncur, res.slot, res.hdl};
  assign out_tuser = res.ok;

endmodule

// File: hdl/gha_store.sv
module gha_store #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gha_pkg::store_ctl_t    ctl,
  input  logic [IW-1:0]          rd_addr,
  input  logic [IW-1:0]          wr_addr,
  output gha_pkg::store_rd_t     rd
);
  import gha_pkg::*;

  logic        active_r [SLOTS];
  logic        gen_vld_r [SLOTS];
  logic [15:0] gen_mem [SLOTS];
  logic [15:0] type_mem [SLOTS];

  logic        rd_act_r;
  logic        rd_gv_r;
  logic [15:0] rd_gen_r;
  logic [15:0] rd_type_r;

  // Active flags and generation valid bits; reset and clear drop them at once.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_r[i]  <= 1'b0;
        gen_vld_r[i] <= 1'b0;
      end
    end else if (ctl.spawn) begin
      active_r[wr_addr] <= 1'b1;
    end else if (ctl.destroy) begin
      active_r[wr_addr]  <= 1'b0;
      gen_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Generation and type memories with one write and one registered read.
  always_ff @(posedge clk) begin
    if (ctl.spawn) begin
      type_mem[wr_addr] <= ctl.typ;
    end
    if (ctl.destroy) begin
      gen_mem[wr_addr] <= ctl.gen;
    end
    if (ctl.rd_en) begin
      rd_gen_r  <= gen_mem[rd_addr];
      rd_type_r <= type_mem[rd_addr];
      rd_act_r  <= active_r[rd_addr];
      rd_gv_r   <= gen_vld_r[rd_addr];
    end
  end

  // A generation never written since reset or clear reads as the start value.
  assign rd.act = rd_act_r;
  assign rd.gen = rd_gv_r ? rd_gen_r : GEN_START;
  assign rd.typ = rd_type_r;

endmodule

// File: hdl/gha_seq.sv
module gha_seq #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gha_pkg::req_t          req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gha_pkg::res_t          res,
  output gha_pkg::store_ctl_t    ctl,
  output logic [IW-1:0]          rd_addr,
  output logic [IW-1:0]          wr_addr,
  input  gha_pkg::store_rd_t     rd
);
  import gha_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);
  localparam logic [16:0]   SLOTS_17 = 17'(SLOTS);

  st_t state_r, state_nxt;

  op_t         op_r, op_nxt;
  logic [31:0] hdl_r, hdl_nxt;
  logic [15:0] typ_r, typ_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic        more_r, more_nxt;
  logic        pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        rok_r, rok_nxt;
  logic [31:0] rhdl_r, rhdl_nxt;
  logic [15:0] rslot_r, rslot_nxt;
  logic [15:0] rncur_r, rncur_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r, out_nxt;

  logic [15:0]   in_low;
  logic          in_hdl_ok;
  logic [IW-1:0] in_idx;
  logic          disp_scan;
  logic          match;
  logic          miss_end;
  logic          out_free;
  logic [15:0]   gen_inc;
  logic [31:0]   found_hdl;
  logic [15:0]   found_slot;

  // Decode of the incoming request for the dispatch decision.
  always_comb begin
    in_low    = req.hdl[15:0];
    in_hdl_ok = (in_low != 16'd0) && ({1'b0, in_low} <= SLOTS_17);
    in_idx    = IW'(in_low - 16'd1);
    case (op_t'(req.func))
      OP_SPAWN:   disp_scan = (count_r < FULL_CNT);
      OP_DESTROY: disp_scan = in_hdl_ok;
      OP_ALIVE:   disp_scan = in_hdl_ok;
      OP_FIND:    disp_scan = ({1'b0, req.cur} < SLOTS_17);
      OP_NTH:     disp_scan = (req.cur < 16'(count_r));
      default:    disp_scan = 1'b0;
    endcase
  end

  // Shared slot compare: one slot per cycle, on the data read the cycle before.
  always_comb begin
    case (op_r)
      OP_SPAWN:   match = !rd.act;
      OP_DESTROY: match = rd.act && (rd.gen == hdl_r[31:16]);
      OP_ALIVE:   match = rd.act && (rd.gen == hdl_r[31:16]);
      OP_FIND:    match = rd.act && (rd.typ == typ_r);
      OP_NTH:     match = rd.act && (16'(seen_r) == cur_r);
      default:    match = 1'b0;
    endcase
    match      = match && pv_r;
    miss_end   = pv_r && !match && !more_r;
    gen_inc    = rd.gen + 16'd1;
    if (gen_inc == 16'd0) begin
      gen_inc = GEN_START;
    end
    found_slot = 16'(pidx_r);
    found_hdl  = {rd.gen, found_slot + 16'd1};
  end

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = disp_scan ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (match || miss_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and store commands.
  always_comb begin
    op_nxt        = op_r;
    hdl_nxt       = hdl_r;
    typ_nxt       = typ_r;
    cur_nxt       = cur_r;
    scan_idx_nxt  = scan_idx_r;
    last_nxt      = last_r;
    more_nxt      = more_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    rok_nxt       = rok_r;
    rhdl_nxt      = rhdl_r;
    rslot_nxt     = rslot_r;
    rncur_nxt     = rncur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctl           = '0;
    ctl.typ       = typ_r;
    ctl.gen       = gen_inc;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt   = op_t'(req.func);
          hdl_nxt  = req.hdl;
          typ_nxt  = req.typ;
          cur_nxt  = req.cur;
          seen_nxt = '0;
          more_nxt = 1'b1;
          rok_nxt  = 1'b0;
          rhdl_nxt = 32'd0;
          rslot_nxt = 16'd0;
          rncur_nxt = 16'd0;
          case (op_t'(req.func))
            OP_SPAWN: begin
              scan_idx_nxt = '0;
              last_nxt     = LAST_IDX;
            end
            OP_DESTROY, OP_ALIVE: begin
              scan_idx_nxt = in_idx;
              last_nxt     = in_idx;
            end
            OP_FIND: begin
              scan_idx_nxt = req.cur[IW-1:0];
              last_nxt     = LAST_IDX;
              rncur_nxt    = req.cur;
            end
            OP_NTH: begin
              scan_idx_nxt = '0;
              last_nxt     = LAST_IDX;
              rncur_nxt    = req.cur;
            end
            OP_CLEAR: begin
              ctl.clear_all = 1'b1;
              count_nxt     = '0;
              rok_nxt       = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the read of the next slot while the previous one is compared.
        if (more_r) begin
          ctl.rd_en = 1'b1;
          pv_nxt    = 1'b1;
          pidx_nxt  = scan_idx_r;
          if (scan_idx_r == last_r) begin
            more_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (pv_r && rd.act && !match) begin
          seen_nxt = seen_r + 1'b1;
        end
        if (match) begin
          pv_nxt    = 1'b0;
          rok_nxt   = 1'b1;
          rslot_nxt = found_slot;
          case (op_r)
            OP_SPAWN: begin
              ctl.spawn = 1'b1;
              count_nxt = count_r + 1'b1;
              rhdl_nxt  = found_hdl;
            end
            OP_DESTROY: begin
              ctl.destroy = 1'b1;
              count_nxt   = count_r - 1'b1;
            end
            OP_FIND, OP_NTH: begin
              rhdl_nxt  = found_hdl;
              rncur_nxt = found_slot + 16'd1;
            end
            default: begin
            end
          endcase
        end else if (miss_end) begin
          if (op_r == OP_DESTROY || op_r == OP_ALIVE) begin
            rslot_nxt = found_slot;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.ok    = rok_r;
          out_nxt.hdl   = rhdl_r;
          out_nxt.slot  = rslot_r;
          out_nxt.ncur  = rncur_r;
          out_nxt.live  = 16'(count_r);
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      more_r      <= more_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    hdl_r      <= hdl_nxt;
    typ_r      <= typ_nxt;
    cur_r      <= cur_nxt;
    scan_idx_r <= scan_idx_nxt;
    last_r     <= last_nxt;
    pidx_r     <= pidx_nxt;
    seen_r     <= seen_nxt;
    rok_r      <= rok_nxt;
    rhdl_r     <= rhdl_nxt;
    rslot_r    <= rslot_nxt;
    rncur_r    <= rncur_nxt;
    out_r      <= out_nxt;
  end

  assign rd_addr   = scan_idx_r;
  assign wr_addr   = pidx_r;
  assign out_valid = out_valid_r;
  assign res       = out_r;

endmodule

// File: hdl/gha_checker.sv
module gha_checker #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gha_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [gha_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import gha_pkg::*;

  localparam logic [15:0] SLOTS_16 = 16'(SLOTS);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only one request is in work: after a transfer the input is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // The live count never exceeds the pool depth.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:64] <= SLOTS_16)
    else $error("live count above pool depth");

  // A failed operation never hands out a handle.
  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:0] == 32'd0)
    else $error("handle returned on failure");

endmodule

bind generational_handle_allocator gha_checker #(.SLOTS(SLOTS)) u_gha_checker (.*);

// File: tb/sv/testbench.sv
module testbench;
  import gha_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 1525;
  localparam int PHASE_ITEMS = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int MAX_REPORTS = 10;

  // Function codes outside the operation set; the block must ignore them.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Operation mixes used by the random phases.
  localparam int MIX_FILL = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN = 2;

  // One row of the directed table: a request and, where pinned, its result.
  typedef struct {
    req_t rq;
    bit   pinned;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Shadow copy of the slot pool.
  bit          slot_act [SLOTS];
  logic [15:0] gen_ctr [SLOTS];
  logic [15:0] slot_typ [SLOTS];
  int          live_total;

  res_t     pending_results [$];
  dir_row_t dir_tab [$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       requests_sent = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  res_t     got;
  res_t     want;

  // Receiver pattern state.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_period = 2;
  int rx_tick = 0;

  generational_handle_allocator #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // Return every slot to free with the starting generation.
  function automatic void pool_wipe();
    for (int i = 0; i < SLOTS; i++) begin
      slot_act[i] = 1'b0;
      gen_ctr[i] = GEN_START;
      slot_typ[i] = 16'd0;
    end
    live_total = 0;
  endfunction

  // Apply one request to the shadow pool and return the result it must give.
  function automatic res_t alloc_step(input req_t r);
    res_t res;
    int   low;
    int   idx;
    int   seen;
    bit   found;
    res = '0;
    found = 1'b0;
    seen = 0;
    low = int'(r.hdl[15:0]);
    idx = low - 1;
    case (r.func)
      OP_SPAWN: begin
        if (live_total < SLOTS) begin
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (!slot_act[i]) begin
              found = 1'b1;
              slot_act[i] = 1'b1;
              slot_typ[i] = r.typ;
              live_total++;
              res.ok = 1'b1;
              res.slot = 16'(i);
              res.hdl = {gen_ctr[i], 16'(i + 1)};
            end
          end
        end
      end
      OP_DESTROY: begin
        if (low != 0 && low <= SLOTS) begin
          res.slot = 16'(idx);
          if (r.hdl != 32'd0 && slot_act[idx] && gen_ctr[idx] == r.hdl[31:16]) begin
            slot_act[idx] = 1'b0;
            slot_typ[idx] = 16'd0;
            gen_ctr[idx] = gen_ctr[idx] + 16'd1;
            // The generation skips zero so that a zero handle never matches.
            if (gen_ctr[idx] == 16'd0) begin
              gen_ctr[idx] = GEN_START;
            end
            if (live_total > 0) begin
              live_total--;
            end
            res.ok = 1'b1;
          end
        end
      end
      OP_ALIVE: begin
        if (low != 0 && low <= SLOTS) begin
          res.slot = 16'(idx);
          res.ok = r.hdl != 32'd0 && slot_act[idx] && gen_ctr[idx] == r.hdl[31:16];
        end
      end
      OP_FIND: begin
        res.ncur = r.cur;
        for (int i = int'(r.cur); i < SLOTS && !found; i++) begin
          if (slot_act[i] && slot_typ[i] == r.typ) begin
            found = 1'b1;
            res.ok = 1'b1;
            res.slot = 16'(i);
            res.hdl = {gen_ctr[i], 16'(i + 1)};
            res.ncur = 16'(i + 1);
          end
        end
      end
      OP_NTH: begin
        res.ncur = r.cur;
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (slot_act[i]) begin
            if (seen == int'(r.cur)) begin
              found = 1'b1;
              res.ok = 1'b1;
              res.slot = 16'(i);
              res.hdl = {gen_ctr[i], 16'(i + 1)};
              res.ncur = 16'(i + 1);
            end else begin
              seen++;
            end
          end
        end
      end
      OP_CLEAR: begin
        pool_wipe();
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.live = 16'(live_total);
    return res;
  endfunction

  function automatic req_t mk_req(input logic [2:0] f, input logic [31:0] h,
                                  input logic [15:0] t, input logic [15:0] c);
    req_t r;
    r.func = f;
    r.hdl = h;
    r.typ = t;
    r.cur = c;
    return r;
  endfunction

  function automatic dir_row_t open_row(input logic [2:0] f, input logic [31:0] h,
                                        input logic [15:0] t, input logic [15:0] c);
    dir_row_t row;
    row.rq = mk_req(f, h, t, c);
    row.pinned = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t pinned_row(input logic [2:0] f, input logic [31:0] h,
                                          input logic [15:0] t, input logic [15:0] c,
                                          input logic ok, input logic [31:0] hout,
                                          input logic [15:0] slot, input logic [15:0] ncur,
                                          input logic [15:0] live);
    dir_row_t row;
    row.rq = mk_req(f, h, t, c);
    row.pinned = 1'b1;
    row.want.ok = ok;
    row.want.hdl = hout;
    row.want.slot = slot;
    row.want.ncur = ncur;
    row.want.live = live;
    return row;
  endfunction

  // Pick a handle for destroy or alive query: mostly live ones, then stale,
  // free, out of range and fully random ones.
  function automatic logic [31:0] pick_handle();
    int s;
    int k;
    s = $urandom_range(SLOTS - 1);
    k = $urandom_range(99);
    if (k < 60) begin
      for (int j = 0; j < SLOTS && !slot_act[s]; j++) begin
        s = (s + 1) % SLOTS;
      end
      return {gen_ctr[s], 16'(s + 1)};
    end else if (k < 75) begin
      return {gen_ctr[s] - 16'(1 + $urandom_range(2)), 16'(s + 1)};
    end else if (k < 85) begin
      return {gen_ctr[s], 16'(s + 1)};
    end else if (k < 92) begin
      if ($urandom_range(1) == 0) begin
        return {16'($urandom), 16'd0};
      end
      return {16'($urandom), 16'($urandom_range(16'hffff, SLOTS + 1))};
    end
    return $urandom;
  endfunction

  // Draw a random request; the mix decides how the pool tends to move.
  function automatic req_t random_req(input int mix);
    req_t r;
    int   pick;
    int   lim_spawn;
    int   lim_destroy;
    int   lim_alive;
    int   lim_find;
    int   lim_nth;
    int   lim_clear;
    case (mix)
      MIX_FILL: begin
        lim_spawn = 55; lim_destroy = 65; lim_alive = 78;
        lim_find = 88; lim_nth = 98; lim_clear = 98;
      end
      MIX_DRAIN: begin
        lim_spawn = 15; lim_destroy = 55; lim_alive = 70;
        lim_find = 82; lim_nth = 94; lim_clear = 95;
      end
      default: begin
        lim_spawn = 30; lim_destroy = 55; lim_alive = 70;
        lim_find = 82; lim_nth = 94; lim_clear = 96;
      end
    endcase
    // Fields the operation does not use still carry random bits.
    r.hdl = $urandom;
    r.typ = 16'($urandom);
    r.cur = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < lim_spawn) begin
      r.func = OP_SPAWN;
      if ($urandom_range(4) != 0) r.typ = 16'($urandom_range(3));
    end else if (pick < lim_destroy) begin
      r.func = OP_DESTROY;
      r.hdl = pick_handle();
    end else if (pick < lim_alive) begin
      r.func = OP_ALIVE;
      r.hdl = pick_handle();
    end else if (pick < lim_find) begin
      r.func = OP_FIND;
      if ($urandom_range(4) != 0) r.typ = 16'($urandom_range(3));
      if ($urandom_range(4) != 0) r.cur = 16'($urandom_range(SLOTS + 2));
    end else if (pick < lim_nth) begin
      r.func = OP_NTH;
      if ($urandom_range(4) != 0) r.cur = 16'($urandom_range(live_total + 2));
    end else if (pick < lim_clear) begin
      r.func = OP_CLEAR;
    end else begin
      r.func = ($urandom_range(1) == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    end
    return r;
  endfunction

  // Sender bursts: after each burst a random gap may follow.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3) != 0) begin
        gap = $urandom_range(12, 1);
        repeat (gap) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
        end
      end
    end
    burst_left--;
  endtask

  // Offer one request, wait for its transfer, then record what it must give.
  task automatic send_req(input req_t r, input bit pinned, input res_t pin_res);
    res_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {r.cur, r.typ, r.hdl};
    in_tuser <= r.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = alloc_step(r);
    pending_results.push_back(pinned ? pin_res : pred);
    requests_sent++;
  endtask

  task automatic note_failure(input string what, input res_t w, input res_t g);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: want ok=%0d hdl=%h slot=%0d ncur=%0d live=%0d", what,
               w.ok, w.hdl, w.slot, w.ncur, w.live);
      $display("  got ok=%0d hdl=%h slot=%0d ncur=%0d live=%0d",
               g.ok, g.hdl, g.slot, g.ncur, g.live);
    end
  endtask

  // Receiver: ready always, at random, rarely, or on a fixed period.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(3);
      rx_left = $urandom_range(200, 10);
      rx_period = $urandom_range(8, 2);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(1);
      2: out_tready <= ($urandom_range(3) == 0);
      default: out_tready <= (rx_tick % rx_period) != 0;
    endcase
  end

  // Compare each result transfer with the oldest pending result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.ok = out_tuser[0];
      got.hdl = out_tdata[31:0];
      got.slot = out_tdata[47:32];
      got.ncur = out_tdata[63:48];
      got.live = out_tdata[79:64];
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          note_failure($sformatf("mismatch on result %0d", results_seen), want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("generational_handle_allocator regression: fail");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases.
  initial begin
    req_t rq;
    int   mix;
    pool_wipe();

    // Empty pool and bad handles first; unused codes follow later in the table.
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0, 16'h0, 16'h0, 0, 32'h0, 0, 0, 0));
    dir_tab.push_back(pinned_row(OP_DESTROY, 32'hffff_ffff, 16'hffff, 16'hffff,
                                 0, 32'h0, 0, 0, 0));
    dir_tab.push_back(pinned_row(OP_NTH, 32'h0, 16'h0, 16'h0, 0, 32'h0, 0, 0, 0));
    dir_tab.push_back(pinned_row(OP_FIND, 32'h0, 16'h0, 16'h0, 0, 32'h0, 0, 0, 0));
    dir_tab.push_back(pinned_row(OP_SPAWN, 32'h0, 16'hffff, 16'h0,
                                 1, 32'h0001_0001, 0, 0, 1));
    dir_tab.push_back(pinned_row(OP_SPAWN, 32'hffff_ffff, 16'h0, 16'hffff,
                                 1, 32'h0001_0002, 1, 0, 2));
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0001_0001, 16'h0, 16'h0,
                                 1, 32'h0, 0, 0, 2));
    // A handle whose generation differs from the slot's is stale.
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0002_0001, 16'h0, 16'h0,
                                 0, 32'h0, 0, 0, 2));
    dir_tab.push_back(pinned_row(OP_FIND, 32'h0, 16'hffff, 16'h0,
                                 1, 32'h0001_0001, 0, 1, 2));
    dir_tab.push_back(pinned_row(OP_FIND, 32'h0, 16'hffff, 16'h1, 0, 32'h0, 0, 1, 2));
    dir_tab.push_back(pinned_row(OP_FIND, 32'h0, 16'h0, 16'hffff,
                                 0, 32'h0, 0, 16'hffff, 2));
    dir_tab.push_back(pinned_row(OP_NTH, 32'h0, 16'h0, 16'h1,
                                 1, 32'h0001_0002, 1, 2, 2));
    dir_tab.push_back(pinned_row(OP_NTH, 32'h0, 16'h0, 16'h2, 0, 32'h0, 0, 2, 2));
    dir_tab.push_back(pinned_row(OP_NTH, 32'h0, 16'h0, 16'hffff,
                                 0, 32'h0, 0, 16'hffff, 2));
    dir_tab.push_back(pinned_row(OP_DESTROY, 32'h0001_0001, 16'h0, 16'h0,
                                 1, 32'h0, 0, 0, 1));
    // The same handle again points at a freed slot.
    dir_tab.push_back(pinned_row(OP_DESTROY, 32'h0001_0001, 16'h0, 16'h0,
                                 0, 32'h0, 0, 0, 1));
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0000_0041, 16'h0, 16'h0,
                                 0, 32'h0, 0, 0, 1));
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0001_0040, 16'h0, 16'h0,
                                 0, 32'h0, 63, 0, 1));
    dir_tab.push_back(pinned_row(FUNC_SPARE_LO, 32'hffff_ffff, 16'hffff, 16'hffff,
                                 0, 32'h0, 0, 0, 1));
    dir_tab.push_back(pinned_row(FUNC_SPARE_HI, 32'hffff_ffff, 16'hffff, 16'hffff,
                                 0, 32'h0, 0, 0, 1));
    dir_tab.push_back(pinned_row(OP_SPAWN, 32'h0, 16'h1234, 16'h0,
                                 1, 32'h0002_0001, 0, 0, 2));
    dir_tab.push_back(open_row(OP_ALIVE, 32'h0002_0001, 16'h0, 16'h0));
    dir_tab.push_back(pinned_row(OP_CLEAR, 32'hffff_ffff, 16'hffff, 16'hffff,
                                 1, 32'h0, 0, 0, 0));
    dir_tab.push_back(pinned_row(OP_ALIVE, 32'h0002_0001, 16'h0, 16'h0,
                                 0, 32'h0, 0, 0, 0));
    dir_tab.push_back(open_row(OP_SPAWN, 32'h0, 16'h5a5a, 16'h0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      pace();
      send_req(dir_tab[i].rq, dir_tab[i].pinned, dir_tab[i].want);
    end

    // Random phases rotate between filling, mixed traffic and draining.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_ITEMS) % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      rq = random_req(mix);
      pace();
      send_req(rq, 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests (directed table, then fill, mixed and drain phases)",
             requests_sent);
    $display("checked %0d results, mismatches %0d, results still pending %0d",
             results_seen, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("generational_handle_allocator regression: pass");
    end else begin
      $display("generational_handle_allocator regression: fail");
    end
    $finish;
  end

endmodule
